// File: hw/rtl/clp_pkg.sv
`default_nettype none

package clp_pkg;

    // Screen size in pixels.
    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 64;

    // Widths of the shared divider.
    localparam int DVW     = 32;
    localparam int DSW     = 16;
    localparam int DIV_CNTW = $clog2(DVW + 1);

    // Status and results that the divider hands back to the sequencer.
    typedef struct packed {
        logic           busy;
        logic           done;
        logic [DVW-1:0] quo;
        logic [DSW-1:0] rem;
    } t_div_res;

endpackage

`default_nettype wire

// File: hw/rtl/clipped_line_plotter.sv
`default_nettype none

// Line plotter with clipping to a SCREEN_W by SCREEN_H screen.
// The input channel (i_valid / o_ready) takes one transaction per segment:
// two signed endpoints and a pen color. The output channel (o_valid /
// i_ready) gives one transaction per on-screen pixel, with o_run_end high on
// the last pixel of the segment. A segment that is wholly off screen gives no
// output transaction at all. A vertical segment gives its two endpoints only.
// A sloped segment is set up in order: the differences are taken, the divider
// is started while the offset product is formed, and two passes of the shared
// bit-serial divider give the slope and the starting offset. It then walks one
// screen column per cycle while the output does not stall, and flushes.
// A vertical segment goes through its two endpoint steps and the flush.
// One segment is worked on at a time; o_ready is high only between segments.
// A pixel waits in a pending register so that the last one can be marked;
// when the receiver stalls, the walk holds until the output register frees.
// A new segment may be accepted while the final pixel still waits for i_ready.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending or unsent pixel.
module clipped_line_plotter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_start_x,
    input  wire logic [15:0] i_start_y,
    input  wire logic [15:0] i_end_x,
    input  wire logic [15:0] i_end_y,
    input  wire logic [15:0] i_pen_color,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_pixel_x,
    output logic [5:0]       o_pixel_y,
    output logic [15:0]      o_pixel_color,
    output logic             o_run_end
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_DIV1  = 4'd3;
    localparam logic [3:0] ST_DIV2  = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_PT1   = 4'd6;
    localparam logic [3:0] ST_PT2   = 4'd7;
    localparam logic [3:0] ST_FLUSH = 4'd8;

    localparam logic signed [16:0] XMAX = 17'(clp_pkg::SCREEN_W - 1);
    localparam logic signed [18:0] YMAX = 19'(clp_pkg::SCREEN_H - 1);

    logic [3:0]          r_state, n_state;

    logic signed [16:0]  r_x1, r_y1, r_x2, r_y2;
    logic [15:0]         r_color;
    logic [15:0]         r_dx, r_dym, r_off;
    logic                r_neg;
    logic [5:0]          r_x, r_hi;
    logic [31:0]         r_prod;
    logic signed [17:0]  r_q, r_qd;
    logic [15:0]         r_r, r_rd;

    logic                r_pend_v;
    logic [5:0]          r_pend_x, r_pend_y;

    logic                r_ovalid;
    logic [5:0]          r_opx, r_opy;
    logic [15:0]         r_ocolor;
    logic                r_olast;

    logic                in_acc;
    logic signed [16:0]  sx1, sy1, sx2, sy2;
    logic                swap;
    logic signed [16:0]  dx17, dy17;
    logic                empty;

    logic                div_start;
    logic [31:0]         div_dividend;
    clp_pkg::t_div_res   div_res;

    logic signed [17:0]  conv_q;
    logic [15:0]         conv_r;

    logic signed [16:0]  cand_x;
    logic signed [18:0]  cand_y;
    logic                cand_state, vis, out_free, step_ok;
    logic                push_pend, push_last;
    logic [16:0]         rsum;
    logic                carry;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);

    // Sign-extend the endpoints and order them so that x rises.
    always_comb begin
        sx1  = {i_start_x[15], i_start_x};
        sy1  = {i_start_y[15], i_start_y};
        sx2  = {i_end_x[15], i_end_x};
        sy2  = {i_end_y[15], i_end_y};
        swap = sx1 > sx2;
        dx17 = r_x2 - r_x1;
        dy17 = r_y2 - r_y1;
        empty = (r_x2 < 17'sd0) || (r_x1 > XMAX);
    end

    // Turn the divider's magnitude result into a floor quotient and a
    // remainder in the range 0 to dx - 1.
    always_comb begin
        if (!r_neg) begin
            conv_q = $signed(div_res.quo[17:0]);
            conv_r = div_res.rem;
        end else if (div_res.rem == '0) begin
            conv_q = -$signed(div_res.quo[17:0]);
            conv_r = '0;
        end else begin
            conv_q = ~$signed(div_res.quo[17:0]);
            conv_r = r_dx - div_res.rem;
        end
    end

    // The shared divider serves the slope first and then the start offset.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_prod;
        if (r_state == ST_MUL) begin
            div_start    = 1'b1;
            div_dividend = {16'd0, r_dym};
        end else if (r_state == ST_DIV1 && div_res.done) begin
            div_start = 1'b1;
        end
    end

    clp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_dx),
        .o_res      (div_res)
    );

    // Candidate pixel of the current step and its screen test. The floor
    // quotient is bumped by one to truncate toward zero for a falling line.
    always_comb begin
        cand_state = 1'b0;
        cand_x     = r_x1;
        cand_y     = {{2{r_y1[16]}}, r_y1};
        unique case (r_state)
            ST_WALK: begin
                cand_state = 1'b1;
                cand_x     = {11'd0, r_x};
                cand_y     = {{2{r_y1[16]}}, r_y1} + {r_q[17], r_q}
                             + 19'((r_neg && r_r != '0) ? 1 : 0);
            end
            ST_PT1: begin
                cand_state = 1'b1;
            end
            ST_PT2: begin
                cand_state = 1'b1;
                cand_x     = r_x2;
                cand_y     = {{2{r_y2[16]}}, r_y2};
            end
            default: begin
                cand_state = 1'b0;
            end
        endcase
        vis = (cand_x >= 17'sd0) && (cand_x <= XMAX)
              && (cand_y >= 19'sd0) && (cand_y <= YMAX);
        out_free = !r_ovalid || i_ready;
        step_ok  = !vis || !r_pend_v || out_free;
        push_pend = (cand_state && step_ok && vis && r_pend_v)
                    || (r_state == ST_FLUSH && r_pend_v && out_free);
        push_last = (r_state == ST_FLUSH);
        rsum  = {1'b0, r_r} + {1'b0, r_rd};
        carry = rsum >= {1'b0, r_dx};
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (sx1 == sx2) ? ST_PT1 : ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = empty ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_res.done) begin
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_res.done) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (step_ok && r_x == r_hi) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_PT1: begin
                if (step_ok) begin
                    n_state = ST_PT2;
                end
            end
            ST_PT2: begin
                if (step_ok) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cand_state && step_ok && vis) begin
                r_pend_v <= 1'b1;
            end else if (push_pend && push_last) begin
                r_pend_v <= 1'b0;
            end
            if (push_pend) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Segment setup and the column walk.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x1    <= swap ? sx2 : sx1;
            r_y1    <= swap ? sy2 : sy1;
            r_x2    <= swap ? sx1 : sx2;
            r_y2    <= swap ? sy1 : sy2;
            r_color <= i_pen_color;
        end
        if (r_state == ST_SETUP) begin
            r_dx  <= dx17[15:0];
            r_neg <= dy17[16];
            r_dym <= dy17[16] ? 16'(-dy17) : dy17[15:0];
            r_off <= (r_x1 < 17'sd0) ? 16'(-r_x1) : 16'd0;
            r_x   <= (r_x1 < 17'sd0) ? 6'd0 : r_x1[5:0];
            r_hi  <= (r_x2 > XMAX) ? XMAX[5:0] : r_x2[5:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_dym * r_off;
        end
        if (r_state == ST_DIV1 && div_res.done) begin
            r_qd <= conv_q;
            r_rd <= conv_r;
        end
        if (r_state == ST_DIV2 && div_res.done) begin
            r_q <= conv_q;
            r_r <= conv_r;
        end
        if (r_state == ST_WALK && step_ok && r_x != r_hi) begin
            r_x <= r_x + 1'b1;
            if (carry) begin
                r_r <= 16'(rsum - {1'b0, r_dx});
                r_q <= r_q + r_qd + 18'sd1;
            end else begin
                r_r <= rsum[15:0];
                r_q <= r_q + r_qd;
            end
        end
    end

    // Pending pixel and output register payload.
    always_ff @(posedge i_clk) begin
        if (cand_state && step_ok && vis) begin
            r_pend_x <= cand_x[5:0];
            r_pend_y <= cand_y[5:0];
        end
        if (push_pend) begin
            r_opx    <= r_pend_x;
            r_opy    <= r_pend_y;
            r_ocolor <= r_color;
            r_olast  <= push_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_x     = r_opx;
    assign o_pixel_y     = r_opy;
    assign o_pixel_color = r_ocolor;
    assign o_run_end     = r_olast;

    // Nothing may be left pending when a new segment can be taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend_v)
        else $error("pending pixel left over at idle");

    // The divider is only started when it is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_res.busy)
        else $error("divider started while busy");

    // The column walk never runs past its right end.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_x <= r_hi))
        else $error("column walk passed its end");

    // No pixel is pushed out while the output still waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |-> !push_pend)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/clp_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module clp_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [clp_pkg::DVW-1:0] i_dividend,
    input  wire logic [clp_pkg::DSW-1:0] i_divisor,
    output clp_pkg::t_div_res          o_res
);

    logic                          r_busy;
    logic                          r_done;
    logic [clp_pkg::DIV_CNTW-1:0]  r_cnt;
    logic [clp_pkg::DSW-1:0]       r_rem;
    logic [clp_pkg::DVW-1:0]       r_quo;
    logic [clp_pkg::DSW-1:0]       r_dsr;

    logic [clp_pkg::DSW:0]         shifted;
    logic                          fits;
    logic [clp_pkg::DSW:0]         diff;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        shifted = {r_rem, r_quo[clp_pkg::DVW-1]};
        fits    = shifted >= {1'b0, r_dsr};
        diff    = shifted - {1'b0, r_dsr};
    end

    // Control: busy while bits remain, done pulses after the last bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= clp_pkg::DIV_CNTW'(clp_pkg::DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == clp_pkg::DIV_CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend in and the quotient bits out.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[clp_pkg::DSW-1:0] : shifted[clp_pkg::DSW-1:0];
            r_quo <= {r_quo[clp_pkg::DVW-2:0], fits};
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire
